FILE: rtl/core/enms_pkg.sv
// enms_pkg: shared constants and types for the edge non-maximum suppression block.
// No dependencies; imported by the interfaces, the line store and the top level.
`timescale 1ns / 1ps
`default_nettype none

package enms_pkg;

	// Line store depth and the widths that follow from it
	localparam int MAX_WIDTH = 1024;
	localparam int ADDR_W    = $clog2(MAX_WIDTH);

	// Field widths
	localparam int MAG_W = 9;
	localparam int ANG_W = 8;
	localparam int FW_W  = 11;
	localparam int FH_W  = 12;

	// Width in use must hold both the register value and MAX_WIDTH itself
	localparam int WU_W = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = FH_W;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

	// Comparison value for angles outside the valid range
	localparam logic [MAG_W-1:0] OUT_OF_RANGE_MAG = MAG_W'(255);

	// Line store access for one pixel
	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
	} ls_ctrl_t;

	// Data written to the line store for one column
	typedef struct packed {
		logic [MAG_W-1:0] top;
		logic [MAG_W-1:0] mid;
		logic [ANG_W-1:0] amid;
	} ls_data_t;

	// One column of the magnitude window
	typedef struct packed {
		logic [MAG_W-1:0] top;
		logic [MAG_W-1:0] mid;
		logic [MAG_W-1:0] bot;
	} win_col_t;

endpackage

`default_nettype wire

FILE: rtl/core/enms_if.sv
// enms_if: valid/ready channel interfaces for pixels, results and configuration.
// Depends on enms_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

// Pixel input channel
interface enms_pix_if import enms_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [MAG_W-1:0] magnitude;
	logic [ANG_W-1:0] angle_deg;

	modport source (output valid, output magnitude, output angle_deg, input ready);
	modport sink   (input valid, input magnitude, input angle_deg, output ready);
endinterface

// Result output channel
interface enms_res_if import enms_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [MAG_W-1:0] suppressed_value;
	logic             frame_last;

	modport source (output valid, output suppressed_value, output frame_last, input ready);
	modport sink   (input valid, input suppressed_value, input frame_last, output ready);
endinterface

// Configuration write channel
interface enms_cfg_if import enms_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/edge_non_max_suppression.sv
// edge_non_max_suppression: streaming 3x3 Canny non-maximum suppression.
// Depends on enms_pkg, enms_if and enms_line_store.
//
//  port  | dir | beat contents                       | accepted when
//  pix   | in  | magnitude, angle_deg                | pix.valid & pix.ready
//  res   | out | suppressed_value, frame_last        | res.valid & res.ready
//  cfg   | in  | index (0 width, 1 height), data     | cfg.valid (ready tied high)
//
// One pixel beat per clock. A beat is registered in stage 1 with its line store
// read, then the window update and compare load the result register. Border
// pixels produce no result beat. Reset clears counters, window and valid flags;
// line memories are not cleared. A stalled result register holds stage 1 when
// its beat emits a result; pix.ready drops only when stage 1 cannot move.
`timescale 1ns / 1ps
`default_nettype none

module edge_non_max_suppression import enms_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	enms_pix_if.sink   pix,
	enms_res_if.source res,
	enms_cfg_if.sink   cfg
);

	// Angle bands
	localparam logic [2:0] BAND_VERT  = 3'd0;
	localparam logic [2:0] BAND_DIAG  = 3'd1;
	localparam logic [2:0] BAND_HORZ  = 3'd2;
	localparam logic [2:0] BAND_ADIAG = 3'd3;
	localparam logic [2:0] BAND_NONE  = 3'd4;

	logic [FW_W-1:0]   frame_width_q;
	logic [FH_W-1:0]   frame_height_q;
	logic [WU_W-1:0]   width_use;
	logic [FH_W-1:0]   height_use;
	logic [ADDR_W-1:0] col_q;
	logic [FH_W-1:0]   row_q;
	logic [WU_W-1:0]   col_next;
	logic [FH_W:0]     row_next;
	logic              col_wrap;
	logic              row_wrap;

	logic              accept;
	logic              adv_s1;
	logic              valid_s1;
	logic              emit_s1;
	logic              last_s1;
	logic [ADDR_W-1:0] col_s1;
	logic [MAG_W-1:0]  mag_s1;
	logic [ANG_W-1:0]  ang_s1;

	ls_ctrl_t          ls_ctrl;
	ls_data_t          ls_wr;
	ls_data_t          ls_rd;

	win_col_t          win_mid_q;
	win_col_t          win_right_q;
	logic [ANG_W-1:0]  amid_q;

	logic [2:0]        band;
	logic [MAG_W-1:0]  centre;
	logic [MAG_W-1:0]  nb_q;
	logic [MAG_W-1:0]  nb_p;

	logic              res_valid_q;
	logic [MAG_W-1:0]  res_value_q;
	logic              res_last_q;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg.data[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Clamped frame geometry
	always_comb begin
		if (WU_W'(frame_width_q) < WU_W'(3))
			width_use = WU_W'(3);
		else if (WU_W'(frame_width_q) > WU_W'(MAX_WIDTH))
			width_use = WU_W'(MAX_WIDTH);
		else
			width_use = WU_W'(frame_width_q);
		height_use = (frame_height_q < FH_W'(3)) ? FH_W'(3) : frame_height_q;
	end

	// Handshake: stage 1 moves unless its result is blocked
	assign adv_s1     = valid_s1 && (!emit_s1 || !res_valid_q || res.ready);
	assign pix.ready  = !valid_s1 || adv_s1;
	assign accept     = pix.valid && pix.ready;

	// Raster position
	assign col_next = WU_W'(col_q) + WU_W'(1);
	assign row_next = {1'b0, row_q} + (FH_W+1)'(1);
	assign col_wrap = col_next >= width_use;
	assign row_wrap = row_next >= {1'b0, height_use};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_next[FH_W-1:0];
			end else begin
				col_q <= col_next[ADDR_W-1:0];
			end
		end
	end

	// Stage 1: pixel beat alongside its line store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_s1  <= pix.magnitude;
			ang_s1  <= pix.angle_deg;
			col_s1  <= col_q;
			emit_s1 <= (row_q >= FH_W'(2)) && (col_q >= ADDR_W'(2));
			last_s1 <= (row_next == {1'b0, height_use}) && (col_next == width_use);
		end
	end

	// Line store: read at accept, write back when the beat leaves stage 1
	assign ls_ctrl = '{rd_en: accept, rd_addr: col_q, wr_en: adv_s1, wr_addr: col_s1};
	assign ls_wr   = '{top: ls_rd.mid, mid: mag_s1, amid: ang_s1};

	enms_line_store u_line_store (
		.clk     (clk),
		.ctrl    (ls_ctrl),
		.wr_data (ls_wr),
		.rd_data (ls_rd)
	);

	// Window shift and centre angle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_mid_q   <= '0;
			win_right_q <= '0;
			amid_q      <= '0;
		end else if (adv_s1) begin
			win_mid_q   <= win_right_q;
			win_right_q <= '{top: ls_rd.top, mid: ls_rd.mid, bot: mag_s1};
			amid_q      <= ls_rd.amid;
		end
	end

	// Quantize the centre angle
	always_comb begin
		case (amid_q) inside
			[8'd0:8'd22], [8'd158:8'd180]: band = BAND_VERT;
			[8'd23:8'd67]:                 band = BAND_DIAG;
			[8'd68:8'd112]:                band = BAND_HORZ;
			[8'd113:8'd157]:               band = BAND_ADIAG;
			default:                       band = BAND_NONE;
		endcase
	end

	// Neighbor pick on the shifted window; centre is the old right-column middle
	assign centre = win_right_q.mid;

	always_comb begin
		case (band)
			BAND_VERT: begin
				nb_q = win_right_q.bot;
				nb_p = win_right_q.top;
			end
			BAND_DIAG: begin
				nb_q = ls_rd.top;
				nb_p = win_mid_q.bot;
			end
			BAND_HORZ: begin
				nb_q = ls_rd.mid;
				nb_p = win_mid_q.mid;
			end
			BAND_ADIAG: begin
				nb_q = win_mid_q.top;
				nb_p = mag_s1;
			end
			default: begin
				nb_q = OUT_OF_RANGE_MAG;
				nb_p = OUT_OF_RANGE_MAG;
			end
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1 && emit_s1) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit_s1) begin
			res_value_q <= (nb_q <= centre && nb_p <= centre) ? centre : '0;
			res_last_q  <= last_s1;
		end
	end

	assign res.valid            = res_valid_q;
	assign res.suppressed_value = res_value_q;
	assign res.frame_last       = res_last_q;

endmodule

`default_nettype wire

FILE: rtl/core/enms_line_store.sv
// enms_line_store: two magnitude line memories and one angle line memory.
// Registered read, one write per cycle. Depends on enms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module enms_line_store import enms_pkg::*; (
	input  wire logic     clk,
	input  wire ls_ctrl_t ctrl,
	input  wire ls_data_t wr_data,
	output ls_data_t      rd_data
);

	logic [MAG_W-1:0] top_mem [MAX_WIDTH];
	logic [MAG_W-1:0] mid_mem [MAX_WIDTH];
	logic [ANG_W-1:0] ang_mem [MAX_WIDTH];

	logic [MAG_W-1:0] top_rd_q;
	logic [MAG_W-1:0] mid_rd_q;
	logic [ANG_W-1:0] ang_rd_q;

	// Write port
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			top_mem[ctrl.wr_addr] <= wr_data.top;
			mid_mem[ctrl.wr_addr] <= wr_data.mid;
			ang_mem[ctrl.wr_addr] <= wr_data.amid;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			top_rd_q <= top_mem[ctrl.rd_addr];
			mid_rd_q <= mid_mem[ctrl.rd_addr];
			ang_rd_q <= ang_mem[ctrl.rd_addr];
		end
	end

	assign rd_data = '{top: top_rd_q, mid: mid_rd_q, amid: ang_rd_q};

endmodule

`default_nettype wire

FILE: bench/tb_edge_non_max_suppression.sv
// tb_edge_non_max_suppression: self-checking bench for the streaming 3x3 non-max suppression.
// Uses enms_pkg, the enms_*_if channel interfaces and the edge_non_max_suppression top level.
`timescale 1ns / 1ps

module tb_edge_non_max_suppression import enms_pkg::*; ();

	// Angle band bounds in whole degrees
	localparam int unsigned ANG_HORZ_LO_MAX = 22;
	localparam int unsigned ANG_DIAG_UP_MAX = 67;
	localparam int unsigned ANG_VERT_MAX    = 112;
	localparam int unsigned ANG_DIAG_DN_MAX = 157;
	localparam int unsigned ANG_HORZ_HI_MIN = 158;
	localparam int unsigned ANG_VALID_MAX   = 180;

	localparam int unsigned SETTLE_CYCLES    = 8;
	localparam int unsigned DRAIN_LIMIT      = 100000;
	localparam int unsigned LONG_HOLD_CYCLES = 400;

	typedef struct packed {
		logic [MAG_W-1:0] magnitude;
		logic [ANG_W-1:0] angle;
	} pixel_t;

	typedef struct packed {
		logic [MAG_W-1:0] value;
		logic             last;
	} nms_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	enms_pix_if pix_bus ();
	enms_res_if res_bus ();
	enms_cfg_if cfg_bus ();

	edge_non_max_suppression dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_bus),
		.res    (res_bus),
		.cfg    (cfg_bus)
	);

	pixel_t   pending_pixels [$];
	nms_out_t awaited_results [$];
	int unsigned fail_count = 0;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	logic pix_fire = 1'b0;

	// Long receiver hold-off, kicked by bumping long_hold_req
	int unsigned long_hold_req = 0;
	int unsigned long_hold_seen = 0;
	int unsigned hold_left = 0;

	// Shadow of the block: config, line stores, window and pixel position
	logic [FW_W-1:0]  cfg_width  = FRAME_WIDTH_RST;
	logic [FH_W-1:0]  cfg_height = FRAME_HEIGHT_RST;
	logic [MAG_W-1:0] mag_row2 [MAX_WIDTH] = '{default: '0};
	logic [MAG_W-1:0] mag_row1 [MAX_WIDTH] = '{default: '0};
	logic [ANG_W-1:0] ang_row1 [MAX_WIDTH] = '{default: '0};
	logic [MAG_W-1:0] win [9] = '{default: '0};
	logic [ANG_W-1:0] centre_ang [2] = '{default: '0};
	int unsigned col_pos = 0;
	int unsigned row_pos = 0;

	function automatic int unsigned used_width(input logic [FW_W-1:0] v);
		if (v < 3)
			return 3;
		if (v > MAX_WIDTH)
			return MAX_WIDTH;
		return 32'(v);
	endfunction

	function automatic int unsigned used_height(input logic [FH_W-1:0] v);
		return (v < 3) ? 3 : 32'(v);
	endfunction

	// Advance the shadow by one pixel and queue the result it produces, if any
	task automatic predict_suppression(input pixel_t px);
		int unsigned wu, hu;
		logic [ADDR_W-1:0] adr;
		logic [ANG_W-1:0] ang_c;
		logic [MAG_W-1:0] q, p;
		logic [MAG_W-1:0] up2, up1, ctr;
		logic [ANG_W-1:0] aup;
		nms_out_t r;
		wu = used_width(cfg_width);
		hu = used_height(cfg_height);
		adr = ADDR_W'(col_pos % MAX_WIDTH);
		up2 = mag_row2[adr];
		up1 = mag_row1[adr];
		aup = ang_row1[adr];
		mag_row2[adr] = up1;
		mag_row1[adr] = px.magnitude;
		ang_row1[adr] = px.angle;

		// shift the window left, new column enters on the right
		for (int k = 0; k < 3; k++) begin
			win[k*3]   = win[k*3+1];
			win[k*3+1] = win[k*3+2];
		end
		win[2] = up2;
		win[5] = up1;
		win[8] = px.magnitude;
		centre_ang[0] = centre_ang[1];
		centre_ang[1] = aup;

		if (row_pos >= 2 && col_pos >= 2) begin
			ang_c = centre_ang[0];
			ctr = win[4];
			q = OUT_OF_RANGE_MAG;
			p = OUT_OF_RANGE_MAG;
			if (ang_c <= ANG_HORZ_LO_MAX ||
					(ang_c >= ANG_HORZ_HI_MIN && ang_c <= ANG_VALID_MAX)) begin
				q = win[7];
				p = win[1];
			end else if (ang_c <= ANG_DIAG_UP_MAX) begin
				q = win[2];
				p = win[6];
			end else if (ang_c <= ANG_VERT_MAX) begin
				q = win[5];
				p = win[3];
			end else if (ang_c <= ANG_DIAG_DN_MAX) begin
				q = win[0];
				p = win[8];
			end
			r.value = (q <= ctr && p <= ctr) ? ctr : '0;
			r.last = (row_pos + 1 == hu) && (col_pos + 1 == wu);
			awaited_results = {awaited_results, r};
		end

		// raster position
		if (col_pos + 1 >= wu) begin
			col_pos = 0;
			row_pos = (row_pos + 1 >= hu) ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
	endtask

	// Random pixel: extremes, near-ties, band edges and out-of-range angles weighted in
	function automatic pixel_t random_pixel();
		pixel_t px;
		logic [ANG_W-1:0] band_edges [12] = '{0, 22, 23, 67, 68, 112, 113, 157, 158, 180, 181, 255};
		case ($urandom_range(7))
			0: px.magnitude = '0;
			1: px.magnitude = '1;
			2, 3: px.magnitude = MAG_W'(248 + $urandom_range(15));
			default: px.magnitude = MAG_W'($urandom_range(511));
		endcase
		case ($urandom_range(7))
			0, 1: px.angle = band_edges[$urandom_range(11)];
			2: px.angle = ANG_W'($urandom_range(255, 181));
			default: px.angle = ANG_W'($urandom_range(180));
		endcase
		return px;
	endfunction

	// Sampling at the rising edge: config shadow, prediction, result check
	always @(posedge clk) begin : sample_side
		nms_out_t want;
		pix_fire <= pix_bus.valid && pix_bus.ready;
		if (arst_n) begin
			if (cfg_bus.valid && cfg_bus.ready) begin
				case (cfg_bus.index)
					REG_FRAME_WIDTH:  cfg_width  = cfg_bus.data[FW_W-1:0];
					REG_FRAME_HEIGHT: cfg_height = cfg_bus.data[FH_W-1:0];
					default: ;
				endcase
			end
			if (pix_bus.valid && pix_bus.ready)
				predict_suppression(pixel_t'{pix_bus.magnitude, pix_bus.angle_deg});
			if (res_bus.valid && res_bus.ready) begin
				if (awaited_results.size() == 0) begin
					$error("result beat with nothing awaited: suppressed_value %0d frame_last %0d",
						res_bus.suppressed_value, res_bus.frame_last);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					if (res_bus.suppressed_value !== want.value) begin
						$error("suppressed_value mismatch: expected %0d, actual %0d",
							want.value, res_bus.suppressed_value);
						fail_count++;
					end
					if (res_bus.frame_last !== want.last) begin
						$error("frame_last mismatch: expected %0d, actual %0d",
							want.last, res_bus.frame_last);
						fail_count++;
					end
				end
			end
		end
	end

	// Pixel driver: a new beat only once the previous one was taken
	always @(negedge clk) begin : pixel_driver
		pixel_t px;
		if (!arst_n) begin
			pix_bus.valid <= 1'b0;
		end else if (!pix_bus.valid || pix_fire) begin
			if (pending_pixels.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				px = pending_pixels.pop_front();
				pix_bus.valid     <= 1'b1;
				pix_bus.magnitude <= px.magnitude;
				pix_bus.angle_deg <= px.angle;
			end else begin
				pix_bus.valid <= 1'b0;
			end
		end
	end

	// Long hold-off counter
	always @(negedge clk) begin
		if (long_hold_req != long_hold_seen) begin
			long_hold_seen <= long_hold_req;
			hold_left <= LONG_HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Result receiver
	always @(negedge clk) begin
		if (!arst_n)
			res_bus.ready <= 1'b0;
		else
			res_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_bus.valid = 1'b1;
		cfg_bus.index = idx;
		cfg_bus.data  = val;
		do @(posedge clk); while (!cfg_bus.ready);
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	task automatic queue_random(input int unsigned n);
		@(posedge clk);
		repeat (n) pending_pixels = {pending_pixels, random_pixel()};
	endtask

	// Wait until every pixel is taken and every result is back, then let the pipe settle
	task automatic wait_drained();
		int unsigned spin = 0;
		while ((pending_pixels.size() != 0 || pix_bus.valid || awaited_results.size() != 0)
				&& spin < DRAIN_LIMIT) begin
			@(negedge clk);
			spin++;
		end
		if (spin >= DRAIN_LIMIT) begin
			$error("%0d awaited results never arrived", awaited_results.size());
			fail_count += awaited_results.size() + 1;
			awaited_results.delete();
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Set both registers and run whole frames of random pixels
	task automatic run_setting(input logic [CFG_DATA_W-1:0] wv, input logic [CFG_DATA_W-1:0] hv,
			input int unsigned frames);
		write_reg(REG_FRAME_WIDTH, wv);
		write_reg(REG_FRAME_HEIGHT, hv);
		queue_random(frames * used_width(wv[FW_W-1:0]) * used_height(hv[FH_W-1:0]));
		wait_drained();
	endtask

	initial begin
		// 5x5 frame: ties, extremes and every angle band on the nine interior pixels
		logic [MAG_W-1:0] dir_mag [25] = '{
			0,   511, 100, 200, 511,
			511, 300, 300, 0,   255,
			50,  300, 511, 256, 1,
			0,   400, 100, 100, 510,
			511, 0,   200, 300, 0};
		logic [ANG_W-1:0] dir_ang [25] = '{
			0,   255, 181, 180, 158,
			255, 22,  23,  67,  0,
			1,   68,  112, 113, 200,
			90,  157, 180, 181, 45,
			255, 254, 0,   128, 255};

		pix_bus.valid     = 1'b0;
		pix_bus.magnitude = '0;
		pix_bus.angle_deg = '0;
		res_bus.ready     = 1'b0;
		cfg_bus.valid     = 1'b0;
		cfg_bus.index     = REG_FRAME_WIDTH;
		cfg_bus.data      = '0;

		// sender mostly busy, receiver mostly stalling
		tx_idle_pct = 8;
		rx_idle_pct = 72;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		write_reg(REG_FRAME_WIDTH, 5);
		write_reg(REG_FRAME_HEIGHT, 5);
		@(posedge clk);
		for (int i = 0; i < 25; i++)
			pending_pixels = {pending_pixels, pixel_t'{dir_mag[i], dir_ang[i]}};
		wait_drained();

		// both registers below range, clamped to 3x3
		run_setting(0, 0, 12);

		// tallest height, then cut the frame short mid-way by lowering the height
		write_reg(REG_FRAME_WIDTH, 3);
		write_reg(REG_FRAME_HEIGHT, 4095);
		queue_random(90);
		wait_drained();
		write_reg(REG_FRAME_HEIGHT, 3);
		queue_random(3);
		wait_drained();

		run_setting(9, 7, 4);

		// sender mostly idle, receiver mostly ready
		tx_idle_pct = 72;
		rx_idle_pct = 8;
		// data bit above the width field set: width masks to 3
		run_setting(12'h803, 3, 4);
		run_setting(16, 5, 5);
		run_setting(4, 12, 4);

		// no idling; long receiver hold-off backs the pipe up into the input
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_reg(REG_FRAME_WIDTH, 33);
		write_reg(REG_FRAME_HEIGHT, 4);
		queue_random(4 * 33 * 4);
		long_hold_req++;
		wait_drained();

		run_setting(2, 1, 10);
		run_setting(5, 6, 5);

		if (fail_count == 0)
			$display("edge_non_max_suppression test passed");
		else
			$display("edge_non_max_suppression test failed");
		$finish;
	end

	// Run limit
	initial begin
		#2000000;
		$display("edge_non_max_suppression test failed");
		$finish;
	end

endmodule
